// ===== hw/rtl/tcgp_pkg.sv =====
// Shared types and constants for the table cell grid placer.
`timescale 1ns / 1ps

package tcgp_pkg;

    // Token classes on the input channel
    localparam logic [3:0] MODE_NEW_TABLE = 4'd0;
    localparam logic [3:0] MODE_ROW_OPEN  = 4'd1;
    localparam logic [3:0] MODE_ROW_CLOSE = 4'd2;
    localparam logic [3:0] MODE_EMPTY     = 4'd3;
    localparam logic [3:0] MODE_CELL_OPEN = 4'd4;
    localparam logic [3:0] MODE_COLSPAN   = 4'd5;
    localparam logic [3:0] MODE_ROWSPAN   = 4'd6;
    localparam logic [3:0] MODE_CLOSE     = 4'd7;
    localparam logic [3:0] MODE_OTHER     = 4'd8;
    localparam logic [3:0] MODE_END       = 4'd9;

    // Field widths of the input beat and of the placed-cell result
    localparam int MODE_W      = 4;
    localparam int SPAN_W      = 7;
    localparam int ROW_FIRST_W = 8;
    localparam int ROW_LAST_W  = 9;
    localparam int COL_W       = 7;

    // Command queue depth between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef logic [MODE_W-1:0]      t_mode;
    typedef logic [SPAN_W-1:0]      t_span;
    typedef logic [ROW_FIRST_W-1:0] t_row_first;
    typedef logic [ROW_LAST_W-1:0]  t_row_last;
    typedef logic [COL_W-1:0]       t_col;

    // Work handed from the token front to the placement back
    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_ROW_OPEN,
        CMD_ROW_CLOSE,
        CMD_PLACE
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
        t_span   colspan;
        t_span   rowspan;
    } t_cmd;

endpackage

// ===== hw/rtl/tcgp_front.sv =====
// Token front: accepts beats, tracks the pending cell and issues commands.
`timescale 1ns / 1ps

module tcgp_front #(
    parameter int MAX_SPAN = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tcgp_pkg::t_mode i_mode,
    input  tcgp_pkg::t_span i_span_value,
    input  logic          i_q_full,
    output logic          o_q_push,
    output tcgp_pkg::t_cmd  o_q_cmd
);

    logic            r_pending;
    tcgp_pkg::t_span r_colspan;
    logic            n_pending;
    tcgp_pkg::t_span n_colspan;
    tcgp_pkg::t_span r_rowspan;
    tcgp_pkg::t_span n_rowspan;
    tcgp_pkg::t_span span_clamped;
    logic            accept;

    // zero becomes one, large values saturate at MAX_SPAN
    function automatic tcgp_pkg::t_span clamp_span(input tcgp_pkg::t_span v);
        tcgp_pkg::t_span res;
        if (v == '0) begin
            res = tcgp_pkg::t_span'(1);
        end else if (32'(v) > MAX_SPAN) begin
            res = tcgp_pkg::t_span'(MAX_SPAN);
        end else begin
            res = v;
        end
        return res;
    endfunction

    assign o_ready      = !i_q_full;
    assign accept       = i_valid && o_ready;
    assign span_clamped = clamp_span(i_span_value);

    // classify the beat
    always_comb begin
        n_pending       = r_pending;
        n_colspan       = r_colspan;
        n_rowspan       = r_rowspan;
        o_q_push        = 1'b0;
        o_q_cmd.op      = tcgp_pkg::CMD_CLEAR;
        o_q_cmd.colspan = r_colspan;
        o_q_cmd.rowspan = r_rowspan;
        if (accept) begin
            if (i_mode == tcgp_pkg::MODE_NEW_TABLE) begin
                n_pending  = 1'b0;
                n_colspan  = tcgp_pkg::t_span'(1);
                n_rowspan  = tcgp_pkg::t_span'(1);
                o_q_push   = 1'b1;
                o_q_cmd.op = tcgp_pkg::CMD_CLEAR;
            end else if (r_pending) begin
                priority case (i_mode)
                    tcgp_pkg::MODE_COLSPAN: n_colspan = span_clamped;
                    tcgp_pkg::MODE_ROWSPAN: n_rowspan = span_clamped;
                    tcgp_pkg::MODE_CLOSE, tcgp_pkg::MODE_END: begin
                        o_q_push   = 1'b1;
                        o_q_cmd.op = tcgp_pkg::CMD_PLACE;
                        n_pending  = 1'b0;
                        n_colspan  = tcgp_pkg::t_span'(1);
                        n_rowspan  = tcgp_pkg::t_span'(1);
                    end
                    default: ;
                endcase
            end else begin
                priority case (i_mode)
                    tcgp_pkg::MODE_ROW_OPEN: begin
                        o_q_push   = 1'b1;
                        o_q_cmd.op = tcgp_pkg::CMD_ROW_OPEN;
                    end
                    tcgp_pkg::MODE_ROW_CLOSE: begin
                        o_q_push   = 1'b1;
                        o_q_cmd.op = tcgp_pkg::CMD_ROW_CLOSE;
                    end
                    tcgp_pkg::MODE_EMPTY: begin
                        o_q_push        = 1'b1;
                        o_q_cmd.op      = tcgp_pkg::CMD_PLACE;
                        o_q_cmd.colspan = tcgp_pkg::t_span'(1);
                        o_q_cmd.rowspan = tcgp_pkg::t_span'(1);
                    end
                    tcgp_pkg::MODE_CELL_OPEN: begin
                        n_pending = 1'b1;
                        n_colspan = tcgp_pkg::t_span'(1);
                        n_rowspan = tcgp_pkg::t_span'(1);
                    end
                    default: ;
                endcase
            end
        end
    end

    // pending cell state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_colspan <= tcgp_pkg::t_span'(1);
            r_rowspan <= tcgp_pkg::t_span'(1);
        end else begin
            r_pending <= n_pending;
            r_colspan <= n_colspan;
            r_rowspan <= n_rowspan;
        end
    end

endmodule

// ===== hw/rtl/tcgp_cmd_queue.sv =====
// Small command FIFO between the token front and the placement back.
`timescale 1ns / 1ps

module tcgp_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcgp_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output tcgp_pkg::t_cmd o_cmd
);

    localparam int PW = $clog2(tcgp_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(tcgp_pkg::QUEUE_DEPTH + 1);

    tcgp_pkg::t_cmd r_slot [tcgp_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == CW'(tcgp_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == tcgp_pkg::QUEUE_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == tcgp_pkg::QUEUE_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/tcgp_back.sv =====
// Placement back: row/column counters, occupancy memory and result register.
`timescale 1ns / 1ps

module tcgp_back #(
    parameter int GRID_ROWS = 256,
    parameter int GRID_COLS = 64,
    parameter int MAX_SPAN  = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_vld,
    input  tcgp_pkg::t_cmd        i_cmd,
    output logic                  o_cmd_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output tcgp_pkg::t_row_first  o_row_first,
    output tcgp_pkg::t_row_last   o_row_last,
    output tcgp_pkg::t_col        o_col_first,
    output tcgp_pkg::t_col        o_col_last,
    output logic                  o_clipped
);

    localparam int RW  = $clog2(GRID_ROWS);
    localparam int R1W = $clog2(GRID_ROWS + MAX_SPAN);
    localparam int CIW = $clog2(GRID_COLS);
    localparam int CCW = $clog2(GRID_COLS + 1);
    localparam int C1W = $clog2(GRID_COLS + MAX_SPAN);
    localparam int CSW = $clog2(GRID_COLS + MAX_SPAN + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SKIP,
        ST_MRD,
        ST_MWR,
        ST_EMIT
    } t_state;

    t_state          r_state;
    logic [RW-1:0]   r_row;
    logic [CCW-1:0]  r_col;
    logic [RW-1:0]   r_hwm;
    logic            r_hwm_vld;
    tcgp_pkg::t_span r_rs;
    tcgp_pkg::t_span r_cs;
    logic [R1W-1:0]  r_r1;
    logic [C1W-1:0]  r_c1;
    logic [RW-1:0]   r_rend;
    logic [RW-1:0]   r_mrow;

    logic                  r_o_valid;
    tcgp_pkg::t_row_first  r_o_row_first;
    tcgp_pkg::t_row_last   r_o_row_last;
    tcgp_pkg::t_col        r_o_col_first;
    tcgp_pkg::t_col        r_o_col_last;
    logic                  r_o_clipped;

    // occupancy memory, one word per grid row
    logic [GRID_COLS-1:0] r_grid [GRID_ROWS];
    logic [GRID_COLS-1:0] r_rdata;
    logic                 r_rd_ok;

    logic                 rd_en;
    logic [RW-1:0]        rd_addr;
    logic                 rd_ok;
    logic                 wr_en;
    logic [GRID_COLS-1:0] wr_data;
    logic [GRID_COLS-1:0] row_word;
    logic [GRID_COLS-1:0] col_mask;
    logic                 skip_occ;
    logic [R1W-1:0]       r1_n;
    logic [C1W-1:0]       c1_n;
    logic [RW-1:0]        rend_n;
    logic [CSW-1:0]       col_sum;

    // rows above the high-water mark were not written since the last clear
    assign row_word = r_rd_ok ? r_rdata : '0;
    assign rd_ok    = r_hwm_vld && (rd_addr <= r_hwm);
    assign skip_occ = (32'(r_col) < GRID_COLS) && row_word[r_col[CIW-1:0]];

    // cell extent once the free column is found
    assign r1_n    = R1W'(r_row) + R1W'(r_rs) - R1W'(1);
    assign c1_n    = C1W'(r_col) + C1W'(r_cs) - C1W'(1);
    assign rend_n  = (32'(r1_n) < GRID_ROWS) ? RW'(r1_n) : RW'(GRID_ROWS - 1);
    assign col_sum = CSW'(r_col) + CSW'(r_cs);

    // columns covered by the cell, clipped to the grid
    always_comb begin
        for (int c = 0; c < GRID_COLS; c++) begin
            col_mask[c] = (32'(r_col) <= c) && (c <= 32'(r_c1));
        end
    end

    // memory port control and command pop
    always_comb begin
        o_cmd_pop = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = r_row;
        wr_en     = 1'b0;
        wr_data   = row_word | col_mask;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_vld) begin
                    o_cmd_pop = 1'b1;
                    rd_en     = (i_cmd.op == tcgp_pkg::CMD_PLACE);
                end
            end
            ST_MRD: begin
                rd_en   = 1'b1;
                rd_addr = r_mrow;
            end
            ST_MWR:  wr_en = 1'b1;
            ST_SKIP, ST_EMIT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_grid[rd_addr];
            r_rd_ok <= rd_ok;
        end
        if (wr_en) begin
            r_grid[r_mrow] <= wr_data;
        end
    end

    // sequencer, counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_row     <= '0;
            r_col     <= '0;
            r_hwm     <= '0;
            r_hwm_vld <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            // the emit step loads the result register itself
            if (r_o_valid && i_ready && (r_state != ST_EMIT)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_vld) begin
                        unique case (i_cmd.op)
                            tcgp_pkg::CMD_CLEAR: begin
                                r_row     <= '0;
                                r_col     <= '0;
                                r_hwm_vld <= 1'b0;
                            end
                            tcgp_pkg::CMD_ROW_OPEN: r_col <= '0;
                            tcgp_pkg::CMD_ROW_CLOSE: begin
                                if (32'(r_row) < GRID_ROWS - 1) begin
                                    r_row <= r_row + 1'b1;
                                end
                            end
                            tcgp_pkg::CMD_PLACE: begin
                                r_rs    <= i_cmd.rowspan;
                                r_cs    <= i_cmd.colspan;
                                r_state <= ST_SKIP;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SKIP: begin
                    // step past occupied columns one a cycle
                    if (skip_occ) begin
                        r_col <= r_col + 1'b1;
                    end else begin
                        r_r1    <= r1_n;
                        r_c1    <= c1_n;
                        r_rend  <= rend_n;
                        r_mrow  <= r_row;
                        r_state <= ST_MRD;
                    end
                end
                ST_MRD: r_state <= ST_MWR;
                ST_MWR: begin
                    if (!r_hwm_vld || r_mrow > r_hwm) begin
                        r_hwm <= r_mrow;
                    end
                    r_hwm_vld <= 1'b1;
                    if (r_mrow == r_rend) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_mrow  <= r_mrow + 1'b1;
                        r_state <= ST_MRD;
                    end
                end
                ST_EMIT: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid     <= 1'b1;
                        r_o_row_first <= tcgp_pkg::t_row_first'(r_row);
                        r_o_row_last  <= tcgp_pkg::t_row_last'(r_r1);
                        r_o_col_first <= tcgp_pkg::t_col'(r_col);
                        r_o_col_last  <= tcgp_pkg::t_col'(r_c1);
                        r_o_clipped   <= (32'(r_r1) >= GRID_ROWS) || (32'(r_c1) >= GRID_COLS);
                        r_col <= (32'(col_sum) > GRID_COLS) ? CCW'(GRID_COLS) : CCW'(col_sum);
                        r_state       <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid     = r_o_valid;
    assign o_row_first = r_o_row_first;
    assign o_row_last  = r_o_row_last;
    assign o_col_first = r_o_col_first;
    assign o_col_last  = r_o_col_last;
    assign o_clipped   = r_o_clipped;

    // column counter never passes the grid width
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) <= GRID_COLS)
        else $error("column counter beyond grid width");

    // marking never walks past the last clipped row
    a_mark_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MWR) |-> (r_mrow <= r_rend))
        else $error("mark row beyond cell end");

    // a write always leaves the high-water mark valid and covering that row
    a_hwm_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MWR) |=> (r_hwm_vld && r_hwm >= $past(r_mrow)))
        else $error("high-water mark misses written row");

    // a result appears only out of the emit step
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_EMIT))
        else $error("result raised outside emit");

endmodule

// ===== hw/rtl/table_cell_grid_placer.sv =====
// Top level of the table cell grid placer: front, command queue and back.
`timescale 1ns / 1ps
//
// Input channel (i_valid/o_ready) carries one token beat: i_mode and
// i_span_value. The front classifies each beat in the cycle it is taken and
// pushes a command into a four-entry queue; o_ready is low only while the
// queue is full. Tokens that change nothing are absorbed without a command.
// Output channel (o_valid/i_ready) carries one placed cell: first and last
// row and column plus a clipped flag.
// In the back, clear, row open and row close are done in the idle step; a
// placed cell steps past occupied columns, then the single occupancy memory
// port does a read-modify-write per spanned row in the grid, a read step and
// a write step per row, and then the cell emits its result.
// The result register frees the back from the receiver: a stalled receiver
// holds the back only when the next cell is ready to be emitted, and the
// front keeps taking beats until the queue fills.
// Reset clears counters and the pending cell at once; a new-table token clears
// the pending cell at once and the counters when its command reaches the back.
// A high-water mark tracks the occupancy memory, so there is no clearing pass
// and the block is ready on the cycle after reset.
//

module table_cell_grid_placer #(
    parameter int GRID_ROWS = 256,
    parameter int GRID_COLS = 64,
    parameter int MAX_SPAN  = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  tcgp_pkg::t_mode       i_mode,
    input  tcgp_pkg::t_span       i_span_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output tcgp_pkg::t_row_first  o_row_first,
    output tcgp_pkg::t_row_last   o_row_last,
    output tcgp_pkg::t_col        o_col_first,
    output tcgp_pkg::t_col        o_col_last,
    output logic                  o_clipped
);

    logic           q_full;
    logic           q_push;
    tcgp_pkg::t_cmd q_in_cmd;
    logic           q_empty;
    logic           q_pop;
    tcgp_pkg::t_cmd q_out_cmd;

    tcgp_front #(
        .MAX_SPAN (MAX_SPAN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_span_value (i_span_value),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_cmd      (q_in_cmd)
    );

    tcgp_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_out_cmd)
    );

    tcgp_back #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS),
        .MAX_SPAN  (MAX_SPAN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_vld   (!q_empty),
        .i_cmd       (q_out_cmd),
        .o_cmd_pop   (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_row_first (o_row_first),
        .o_row_last  (o_row_last),
        .o_col_first (o_col_first),
        .o_col_last  (o_col_last),
        .o_clipped   (o_clipped)
    );

endmodule
